// ----- design/tcpwq_pkg.sv -----
// shared types and constants for the two-class priority wait queue
// no dependencies
package tcpwq_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_BITS  = 16;
	localparam int WAIT_BITS = 16;
	localparam int CNT_BITS  = $clog2(DEPTH + 2);
	localparam int IDX_BITS  = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		OP_ENQ    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_TICK   = 3'd2,
		OP_TRIM   = 3'd3,
		OP_RELOAD = 3'd4,
		OP_QUERY  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		K_STATUS  = 2'd0,
		K_RELEASE = 2'd1,
		K_DROP    = 2'd2,
		K_QUERY   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CLOSED  = 2'd1,
		ST_DUP     = 2'd2,
		ST_NOTFND  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_LIMIT = 2'd0,
		REG_TIME  = 2'd1,
		REG_OPEN  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_DROP, S_RELEASE, S_REPORT, S_STATUS
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic do_insert;
		logic do_delete;
		logic do_tick;
		logic do_reload;
		logic do_pop_tail;
		logic do_pop_head;
		logic load_out;
		logic [1:0] out_kind;
		logic out_sel_tail;
		logic out_sel_head;
		logic out_sel_hit;
		logic [1:0] out_status;
		logic out_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic over_limit;
		logic head_zero;
		logic empty;
	} sts_t;

endpackage

// ----- design/tcpwq_dp.sv -----
// queue datapath: entry registers, key match, insert, delete, waits, result register
// depends on tcpwq_pkg
module tcpwq_dp (
	input  logic clk,
	input  logic arst_n,
	input  tcpwq_pkg::cmd_t cmd,
	output tcpwq_pkg::sts_t sts,
	input  logic [15:0] in_key,
	input  logic in_prio,
	input  logic [4:0] limit,
	input  logic [15:0] tpe,
	output logic [1:0] o_kind,
	output logic [1:0] o_status,
	output logic [15:0] o_key,
	output logic o_prio,
	output logic [4:0] o_ticket,
	output logic [15:0] o_wait,
	output logic [4:0] o_occ,
	output logic o_last
);
	import tcpwq_pkg::*;

	localparam int SLOTS = DEPTH + 1;

	logic [KEY_BITS-1:0] key_q [SLOTS];
	logic prio_q [SLOTS];
	logic [4:0] tick_q [SLOTS];
	logic [WAIT_BITS-1:0] wait_q [SLOTS];
	logic [CNT_BITS-1:0] cnt_q;

	logic [SLOTS-1:0] match;
	logic [IDX_BITS-1:0] hit_idx;
	logic [IDX_BITS-1:0] ins_pos;
	logic [CNT_BITS-1:0] eff_lim;
	logic [CNT_BITS-1:0] new_cnt;
	logic [IDX_BITS-1:0] tail_idx;
	logic [CNT_BITS-1:0] first_live;

	always_comb begin
		hit_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			match[i] = (CNT_BITS'(i) < cnt_q) && (key_q[i] == KEY_BITS'(in_key));
			if (match[i]) hit_idx = IDX_BITS'(i);
		end
	end

	// priority entries first: position is count of priority entries, or tail for normal
	always_comb begin
		ins_pos = IDX_BITS'(cnt_q);
		if (in_prio) begin
			ins_pos = '0;
			for (int i = 0; i < SLOTS; i++)
				if ((CNT_BITS'(i) < cnt_q) && prio_q[i]) ins_pos = IDX_BITS'(i + 1);
		end
	end

	// first entry with wait left; entries ahead of it all leave in this release run
	always_comb begin
		first_live = cnt_q;
		for (int i = SLOTS - 1; i >= 0; i--)
			if ((CNT_BITS'(i) < cnt_q) && (wait_q[i] != '0)) first_live = CNT_BITS'(i);
	end

	always_comb begin
		if (limit == 5'd0) eff_lim = CNT_BITS'(1);
		else if (32'(limit) > DEPTH) eff_lim = CNT_BITS'(DEPTH);
		else eff_lim = CNT_BITS'(limit);
	end

	assign new_cnt  = cnt_q + CNT_BITS'(1);
	assign tail_idx = IDX_BITS'(cnt_q - CNT_BITS'(1));

	assign sts.hit        = |match;
	assign sts.over_limit = cnt_q > eff_lim;
	assign sts.head_zero  = (cnt_q != '0) && (wait_q[0] == '0);
	assign sts.empty      = cnt_q == '0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (cmd.do_insert) begin
				if (IDX_BITS'(i) == ins_pos) begin
					key_q[i]  <= KEY_BITS'(in_key);
					prio_q[i] <= in_prio;
					tick_q[i] <= (32'(new_cnt) > DEPTH) ? 5'(DEPTH) : 5'(new_cnt);
					wait_q[i] <= WAIT_BITS'(tpe);
				end else if (IDX_BITS'(i) > ins_pos && i > 0) begin
					key_q[i]  <= key_q[i-1];
					prio_q[i] <= prio_q[i-1];
					tick_q[i] <= tick_q[i-1];
					wait_q[i] <= wait_q[i-1];
				end
			end else if (cmd.do_delete || cmd.do_pop_head) begin
				if ((cmd.do_pop_head || IDX_BITS'(i) >= hit_idx) && i < SLOTS - 1) begin
					key_q[i]  <= key_q[i+1];
					prio_q[i] <= prio_q[i+1];
					tick_q[i] <= tick_q[i+1];
					wait_q[i] <= wait_q[i+1];
				end
			end else if (cmd.do_tick) begin
				if (wait_q[i] != '0) wait_q[i] <= wait_q[i] - WAIT_BITS'(1);
			end else if (cmd.do_reload) begin
				wait_q[i] <= WAIT_BITS'(tpe);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.do_insert) begin
			cnt_q <= new_cnt;
		end else if (cmd.do_delete || cmd.do_pop_head || cmd.do_pop_tail) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	// result register, loaded in the same cycle as the pop that it reports, from the values before it
	// occupancy is the count left once the whole operation is done
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			o_kind   <= cmd.out_kind;
			o_status <= cmd.out_status;
			o_last   <= cmd.out_last;
			if (cmd.out_sel_tail) o_occ <= 5'(eff_lim);
			else if (cmd.out_sel_head) o_occ <= 5'(cnt_q - first_live);
			else o_occ <= 5'(cnt_q);
			if (cmd.out_sel_tail) begin
				o_key <= 16'(key_q[tail_idx]); o_prio <= prio_q[tail_idx];
				o_ticket <= tick_q[tail_idx]; o_wait <= 16'(wait_q[tail_idx]);
			end else if (cmd.out_sel_head) begin
				o_key <= 16'(key_q[0]); o_prio <= prio_q[0];
				o_ticket <= tick_q[0]; o_wait <= 16'(wait_q[0]);
			end else if (cmd.out_sel_hit) begin
				o_key <= 16'(key_q[hit_idx]); o_prio <= prio_q[hit_idx];
				o_ticket <= tick_q[hit_idx]; o_wait <= 16'(wait_q[hit_idx]);
			end else begin
				o_key <= '0; o_prio <= 1'b0; o_ticket <= '0; o_wait <= '0;
			end
		end
	end

endmodule

// ----- design/tcpwq_ctrl.sv -----
// controller state machine: sequences one operation and its results
// depends on tcpwq_pkg
module tcpwq_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] in_op,
	input  logic q_open,
	output logic out_valid,
	input  logic out_ready,
	input  tcpwq_pkg::sts_t sts,
	output tcpwq_pkg::cmd_t cmd
);
	import tcpwq_pkg::*;

	state_t state_q, state_d;
	logic [2:0] op_q;
	logic [1:0] stat_q, stat_d;
	logic out_busy;

	assign out_valid = (state_q == S_REPORT);
	assign in_ready  = (state_q == S_IDLE);
	assign out_busy  = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= '0;
			stat_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
			if (in_valid && in_ready) op_q <= in_op;
		end
	end

	// S_REPORT holds a loaded result; next_q tells where to go after transfer
	state_t next_q, next_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) next_q <= S_IDLE;
		else next_q <= next_d;
	end

	always_comb begin
		state_d = state_q;
		next_d  = next_q;
		stat_d  = stat_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
					stat_d  = ST_OK;
				end
			end
			S_EXEC: begin
				state_d = S_STATUS;
				case (op_q)
					OP_ENQ: begin
						if (!q_open) stat_d = ST_CLOSED;
						else if (sts.hit) stat_d = ST_DUP;
						else begin
							cmd.do_insert = 1'b1;
							state_d = S_DROP;
						end
					end
					OP_REMOVE: begin
						if (sts.hit) cmd.do_delete = 1'b1;
						else stat_d = ST_NOTFND;
					end
					OP_TICK: begin
						if (!sts.empty) begin
							cmd.do_tick = 1'b1;
							state_d = S_RELEASE;
						end
					end
					OP_TRIM:   state_d = S_DROP;
					OP_RELOAD: cmd.do_reload = 1'b1;
					OP_QUERY: begin
						if (sts.hit) begin
							cmd.load_out = 1'b1;
							cmd.out_kind = K_QUERY;
							cmd.out_sel_hit = 1'b1;
							state_d = S_REPORT;
							next_d  = S_STATUS;
						end else stat_d = ST_NOTFND;
					end
					default: ;
				endcase
			end
			S_DROP: begin
				if (sts.over_limit) begin
					cmd.load_out = 1'b1;
					cmd.out_kind = K_DROP;
					cmd.out_sel_tail = 1'b1;
					cmd.do_pop_tail = 1'b1;
					state_d = S_REPORT;
					next_d  = S_DROP;
				end else state_d = S_STATUS;
			end
			S_RELEASE: begin
				if (sts.head_zero) begin
					cmd.load_out = 1'b1;
					cmd.out_kind = K_RELEASE;
					cmd.out_sel_head = 1'b1;
					cmd.do_pop_head = 1'b1;
					state_d = S_REPORT;
					next_d  = S_RELEASE;
				end else state_d = S_STATUS;
			end
			S_STATUS: begin
				cmd.load_out = 1'b1;
				cmd.out_kind = K_STATUS;
				cmd.out_status = stat_q;
				cmd.out_last = 1'b1;
				state_d = S_REPORT;
				next_d  = S_IDLE;
			end
			S_REPORT: begin
				if (out_ready && !out_busy) state_d = next_q;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- design/two_class_priority_wait_queue.sv -----
// two-class strict-priority wait queue with tail drop, top level
// a status-only op steps from accept through execute, status load, report and idle
// a drop or release scan adds its scan state and a report per dropped or released entry
// a query hit adds a report; at most 16 entry results; out_ready stalls hold the report state
// one operation at a time; reset: queue empty, limit 5, time per entry 5, queue closed
// depends on tcpwq_pkg, tcpwq_ctrl, tcpwq_dp
module two_class_priority_wait_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] op,
	input  logic [15:0] key,
	input  logic priority_req,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] kind,
	output logic [1:0] status,
	output logic [15:0] entry_key,
	output logic entry_priority,
	output logic [4:0] entry_ticket,
	output logic [15:0] entry_wait,
	output logic [4:0] occupancy,
	output logic last
);
	import tcpwq_pkg::*;

	logic [4:0] limit_q;
	logic [15:0] tpe_q;
	logic open_q;
	logic [15:0] key_q;
	logic prio_q;
	cmd_t cmd;
	sts_t sts;

	// config always writable; the user must write it only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 5'd5;
			tpe_q   <= 16'd5;
			open_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LIMIT: limit_q <= cfg_data[4:0];
				REG_TIME:  tpe_q   <= cfg_data;
				REG_OPEN:  open_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// capture the request on transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_q  <= key;
			prio_q <= priority_req;
		end
	end

	tcpwq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_op(op),
		.q_open(open_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	tcpwq_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts),
		.in_key(key_q), .in_prio(prio_q),
		.limit(limit_q), .tpe(tpe_q),
		.o_kind(kind), .o_status(status), .o_key(entry_key),
		.o_prio(entry_priority), .o_ticket(entry_ticket),
		.o_wait(entry_wait), .o_occ(occupancy), .o_last(last)
	);

endmodule

// ----- dv/two_class_priority_wait_queue_tb.sv -----
// self-checking testbench for the two-class priority wait queue
// directed stimulus table, then random traffic, checked against an in-bench queue model
// depends on tcpwq_pkg and two_class_priority_wait_queue
`timescale 1ns / 1ps

module two_class_priority_wait_queue_tb;
	import tcpwq_pkg::*;

	typedef struct {
		logic [15:0] key;
		logic        prio;
		logic [4:0]  ticket;
		logic [15:0] wait_left;
	} slot_s;

	typedef struct {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [15:0] entry_key;
		logic        entry_priority;
		logic [4:0]  entry_ticket;
		logic [15:0] entry_wait;
		logic [4:0]  occupancy;
		logic        last;
	} result_s;

	typedef struct {
		op_t         op;
		logic [15:0] key;
		logic        prio;
		logic        fixed;   // row carries a typed-in status result
		status_t     status;
		logic [4:0]  occupancy;
	} row_s;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid, in_ready;
	logic [2:0] op;
	logic [15:0] key;
	logic priority_req;
	logic out_valid, out_ready;
	logic [1:0] kind, status;
	logic [15:0] entry_key;
	logic entry_priority;
	logic [4:0] entry_ticket;
	logic [15:0] entry_wait;
	logic [4:0] occupancy;
	logic last;

	two_class_priority_wait_queue dut (.*);

	// model state
	slot_s   model_q[$];
	logic [4:0]  lim_reg;
	logic [15:0] time_reg;
	logic        open_reg;

	result_s expected_results[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 0, recv_stall = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog on a generous cycle budget
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("two_class_priority_wait_queue_tb: done, errors");
			$finish;
		end
	end

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		errors++;
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
	endtask

	function automatic int eff_limit();
		if (lim_reg < 1) return 1;
		if (lim_reg > DEPTH) return DEPTH;
		return int'(lim_reg);
	endfunction

	function automatic result_s mk(input kind_t k, input slot_s s, input logic use_slot);
		result_s r;
		r.kind = k;
		r.status = ST_OK;
		r.entry_key = use_slot ? s.key : '0;
		r.entry_priority = use_slot ? s.prio : 1'b0;
		r.entry_ticket = use_slot ? s.ticket : '0;
		r.entry_wait = use_slot ? s.wait_left : '0;
		r.occupancy = '0;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic int find_key(input logic [15:0] k);
		foreach (model_q[i]) if (model_q[i].key == k) return i;
		return -1;
	endfunction

	// apply one operation to the model and queue up what the block should send
	task automatic predict_queue_op(input logic [2:0] o, input logic [15:0] k, input logic p);
		result_s outs[$];
		slot_s e, none;
		status_t st;
		int pos, idx;
		st = ST_OK;
		none = '{default: 0};
		case (o)
			OP_ENQ: begin
				if (!open_reg) st = ST_CLOSED;
				else if (find_key(k) >= 0) st = ST_DUP;
				else begin
					// priority goes after last priority entry, normal at tail
					pos = 0;
					if (p) while (pos < model_q.size() && model_q[pos].prio) pos++;
					else pos = model_q.size();
					e.key = k;
					e.prio = p;
					e.ticket = 5'((model_q.size() + 1 > DEPTH) ? DEPTH : model_q.size() + 1);
					e.wait_left = time_reg;
					model_q.insert(pos, e);
					while (model_q.size() > eff_limit())
						outs.push_back(mk(K_DROP, model_q.pop_back(), 1'b1));
				end
			end
			OP_REMOVE: begin
				idx = find_key(k);
				if (idx < 0) st = ST_NOTFND;
				else model_q.delete(idx);
			end
			OP_TICK: begin
				foreach (model_q[i]) if (model_q[i].wait_left > 0) model_q[i].wait_left--;
				while (model_q.size() > 0 && model_q[0].wait_left == 0)
					outs.push_back(mk(K_RELEASE, model_q.pop_front(), 1'b1));
			end
			OP_TRIM: while (model_q.size() > eff_limit())
				outs.push_back(mk(K_DROP, model_q.pop_back(), 1'b1));
			OP_RELOAD: foreach (model_q[i]) model_q[i].wait_left = time_reg;
			OP_QUERY: begin
				idx = find_key(k);
				if (idx < 0) st = ST_NOTFND;
				else outs.push_back(mk(K_QUERY, model_q[idx], 1'b1));
			end
			default: ;
		endcase
		outs.push_back(mk(K_STATUS, none, 1'b0));
		outs[outs.size() - 1].status = st;
		outs[outs.size() - 1].last = 1'b1;
		foreach (outs[i]) begin
			outs[i].occupancy = 5'(model_q.size());
			expected_results.push_back(outs[i]);
		end
	endtask

	// result checker, sampled at the rising edge
	always @(posedge clk) begin
		result_s w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report("unexpected result transfer", 16'(kind), 16'(K_STATUS));
			end else begin
				w = expected_results.pop_front();
				if (kind !== w.kind) report("kind", 16'(kind), 16'(w.kind));
				if (status !== w.status) report("status", 16'(status), 16'(w.status));
				if (entry_key !== w.entry_key) report("entry_key", entry_key, w.entry_key);
				if (entry_priority !== w.entry_priority)
					report("entry_priority", 16'(entry_priority), 16'(w.entry_priority));
				if (entry_ticket !== w.entry_ticket)
					report("entry_ticket", 16'(entry_ticket), 16'(w.entry_ticket));
				if (entry_wait !== w.entry_wait) report("entry_wait", entry_wait, w.entry_wait);
				if (occupancy !== w.occupancy)
					report("occupancy", 16'(occupancy), 16'(w.occupancy));
				if (last !== w.last) report("last", 16'(last), 16'(w.last));
			end
		end
	end

	// receiver stalls, changed at the falling edge
	always @(negedge clk) begin
		if (!arst_n) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// idle gaps in the sender
	task automatic sender_gap();
		while ($urandom_range(99) < send_idle) @(negedge clk);
	endtask

	task automatic send_item(input logic [2:0] o, input logic [15:0] k, input logic p);
		sender_gap();
		in_valid = 1'b1;
		op = o;
		key = k;
		priority_req = p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_queue_op(o, k, p);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// wait until the block has sent everything, plus slack for trailing work
	task automatic drain();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_LIMIT: lim_reg = v[4:0];
			REG_TIME:  time_reg = v;
			REG_OPEN:  open_reg = v[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// random operation, weighted toward enqueues and hits on live keys
	task automatic random_item();
		int r;
		logic [15:0] k;
		logic [2:0] o;
		r = $urandom_range(99);
		if (model_q.size() > 0 && $urandom_range(2) != 0)
			k = model_q[$urandom_range(model_q.size() - 1)].key;
		else k = 16'($urandom);
		if (r < 40) o = OP_ENQ;
		else if (r < 52) o = OP_REMOVE;
		else if (r < 75) o = OP_TICK;
		else if (r < 82) o = OP_TRIM;
		else if (r < 87) o = OP_RELOAD;
		else if (r < 97) o = OP_QUERY;
		else o = 3'($urandom_range(7, 6));
		send_item(o, k, 1'($urandom));
	endtask

	row_s dir_rows[$];

	initial begin
		logic fresh;
		result_s got_status;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; op = 0; key = 0; priority_req = 0;
		out_ready = 1;
		arst_n = 0;
		model_q = {};
		lim_reg = 5; time_reg = 5; open_reg = 0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: closed queue, empty tick, absent keys, unknown ops
		dir_rows = '{
			'{OP_ENQ,    16'h0000, 1'b0, 1, ST_CLOSED, 0},
			'{OP_TICK,   16'h0000, 1'b0, 1, ST_OK,     0},
			'{OP_REMOVE, 16'hFFFF, 1'b0, 1, ST_NOTFND, 0},
			'{OP_QUERY,  16'h1234, 1'b1, 1, ST_NOTFND, 0},
			'{op_t'(3'd6), 16'h5555, 1'b1, 1, ST_OK,   0},
			'{op_t'(3'd7), 16'hAAAA, 1'b0, 1, ST_OK,   0}
		};
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].prio);
			got_status = expected_results[expected_results.size() - 1];
			if (dir_rows[i].fixed && (got_status.status != dir_rows[i].status ||
					got_status.occupancy != dir_rows[i].occupancy))
				report("directed table", 16'(got_status.status), 16'(dir_rows[i].status));
		end
		drain();

		// open with a tiny wait, fill past the limit with both classes
		write_reg(REG_OPEN, 16'd1);
		write_reg(REG_TIME, 16'd2);
		write_reg(REG_LIMIT, 16'd16);
		dir_rows = '{
			'{OP_ENQ,    16'h0000, 1'b0, 0, ST_OK, 0},
			'{OP_ENQ,    16'hFFFF, 1'b1, 0, ST_OK, 0},
			'{OP_ENQ,    16'h0000, 1'b1, 0, ST_DUP, 0},
			'{OP_ENQ,    16'h0010, 1'b1, 0, ST_OK, 0},
			'{OP_ENQ,    16'h0020, 1'b0, 0, ST_OK, 0},
			'{OP_QUERY,  16'hFFFF, 1'b0, 0, ST_OK, 0},
			'{OP_REMOVE, 16'h0010, 1'b0, 0, ST_OK, 0},
			'{OP_TICK,   16'h0000, 1'b0, 0, ST_OK, 0},
			'{OP_RELOAD, 16'h0000, 1'b0, 0, ST_OK, 0},
			'{OP_TICK,   16'h0000, 1'b0, 0, ST_OK, 0},
			'{OP_TICK,   16'h0000, 1'b0, 0, ST_OK, 0}
		};
		foreach (dir_rows[i]) send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].prio);
		// full store: seventeen enqueues at DEPTH, ticket saturates
		for (int i = 0; i < 17; i++) send_item(OP_ENQ, 16'(16'h0100 + i), 1'(i[0]));
		drain();
		// limit zero acts as one, then trim
		write_reg(REG_LIMIT, 16'd0);
		send_item(OP_TRIM, 16'h0000, 1'b0);
		send_item(OP_ENQ, 16'h7777, 1'b1);
		drain();
		// zero wait: entries leave on the next tick; limit above depth
		write_reg(REG_TIME, 16'd0);
		write_reg(REG_LIMIT, 16'd31);
		send_item(OP_ENQ, 16'h0200, 1'b0);
		send_item(OP_RELOAD, 16'h0000, 1'b0);
		send_item(OP_TICK, 16'h0000, 1'b0);
		drain();
		write_reg(REG_TIME, 16'hFFFF);
		send_item(OP_ENQ, 16'h0300, 1'b1);
		send_item(OP_QUERY, 16'h0300, 1'b0);
		drain();

		// random phases over several settings and idle profiles
		for (int ph = 0; ph < 7; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 57; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 57; end
				default: begin send_idle = 13; recv_stall = 13; end
			endcase
			write_reg(REG_LIMIT, 16'($urandom_range(16, 0)));
			write_reg(REG_TIME, (ph == 6) ? 16'hFFFF : 16'($urandom_range(4, 1)));
			write_reg(REG_OPEN, 16'(ph != 3));
			for (int i = 0; i < 36; i++) begin
				random_item();
				// pause until the block has caught up
				if (i == 18) while (expected_results.size() != 0) @(negedge clk);
			end
			drain();
		end

		if (errors == 0) begin
			$display("two_class_priority_wait_queue_tb: done, clean");
		end else begin
			$display("two_class_priority_wait_queue_tb: done, errors");
		end
		$finish;
	end

endmodule
